### sv/pdst_pkg.sv
`default_nettype none
package pdst_pkg;
	localparam int MAX_PROCS = 64;
	localparam int TIME_BITS = 32;
	localparam int ID_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_EXIT   = 3'd1;
	localparam logic [2:0] CMD_BLOCK  = 3'd2;
	localparam logic [2:0] CMD_WAKE   = 3'd3;
	localparam logic [2:0] CMD_TIMER  = 3'd4;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_BAD_CMD    = 3'd1;
	localparam logic [2:0] STS_NO_RUN     = 3'd2;
	localparam logic [2:0] STS_NOT_BLOCKED = 3'd3;
	localparam logic [2:0] STS_IN_USE     = 3'd4;

	typedef enum logic [2:0] {
		PS_FREE    = 3'd0,
		PS_READY   = 3'd1,
		PS_RUNNING = 3'd2,
		PS_BLOCKED = 3'd3,
		PS_EXITED  = 3'd4
	} pstate_t;

	typedef logic [TIME_BITS-1:0] ptime_t;

	typedef struct packed {
		pstate_t st;
		ptime_t  entry;
		ptime_t  run;
		ptime_t  rdy;
		ptime_t  blk;
	} prow_t;
endpackage
`default_nettype wire

### sv/pdst_evt_if.sv
`default_nettype none
interface pdst_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [5:0]  proc_id;
	logic [31:0] event_time;
	modport source (output valid, cmd, proc_id, event_time, input ready);
	modport sink (input valid, cmd, proc_id, event_time, output ready);
endinterface
`default_nettype wire

### sv/pdst_res_if.sv
`default_nettype none
interface pdst_res_if;
	logic        valid;
	logic        ready;
	logic        run_valid;
	logic [5:0]  run_id;
	logic        exit_valid;
	logic [5:0]  exit_id;
	logic [31:0] exit_run_time;
	logic [31:0] exit_ready_time;
	logic [31:0] exit_blocked_time;
	logic [31:0] idle_total;
	logic [2:0]  status;
	modport source (output valid, run_valid, run_id, exit_valid, exit_id, exit_run_time,
		exit_ready_time, exit_blocked_time, idle_total, status, input ready);
	modport sink (input valid, run_valid, run_id, exit_valid, exit_id, exit_run_time,
		exit_ready_time, exit_blocked_time, idle_total, status, output ready);
endinterface
`default_nettype wire

### sv/pdst_ram.sv
`default_nettype none
module pdst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### sv/process_dispatcher_with_state_times.sv
// Event-driven process dispatcher: each item (create, exit, block, wake, timer) updates a
// FIFO ready queue, the running slot and per-process time accounts, and returns one result
// item. A single shared adder does all time arithmetic under a small sequencer, and process
// records sit in a RAM with registered read. As its command needs, an item steps through the
// idle-time update, a record read, subtract, add and write-back, and a dispatch of the ready
// head when nothing runs (always so for a timer with a process running). The input is not
// ready until the sequencer is back in idle, and a result item held by the receiver keeps the
// sequencer in its last step. A valid flag per process marks free entries, so no clearing pass
// is needed after reset.
`default_nettype none
module process_dispatcher_with_state_times
	import pdst_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	pdst_evt_if.sink    evt,
	pdst_res_if.source  res
);
	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_ID1  = 11'b00000000010,
		ST_ID2  = 11'b00000000100,
		ST_RD   = 11'b00000001000,
		ST_SUB  = 11'b00000010000,
		ST_ADD  = 11'b00000100000,
		ST_WR   = 11'b00001000000,
		ST_CHK  = 11'b00010000000,
		ST_POP  = 11'b00100000000,
		ST_POPW = 11'b01000000000,
		ST_DONE = 11'b10000000000
	} seq_t;

	seq_t               st_q;
	logic [2:0]         cmd_q;
	logic [ID_W-1:0]    pid_q;
	ptime_t             t_q;
	ptime_t             last_q;
	ptime_t             idle_q;
	ptime_t             d_q;
	logic               was_idle_q;
	logic [ID_W-1:0]    cur_q;
	logic               cur_vld_q;
	logic [ID_W-1:0]    tgt_q;
	pstate_t            to_q;
	logic               disp_q;
	prow_t              row_q;
	logic [2:0]         sts_q;
	logic               ex_vld_q;
	logic [ID_W-1:0]    ex_id_q;
	ptime_t             ex_run_q;
	ptime_t             ex_rdy_q;
	ptime_t             ex_blk_q;
	logic [ID_W-1:0]    head_q;
	logic [ID_W-1:0]    tail_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               vld_q [MAX_PROCS];
	logic               ov_q;

	prow_t              rd_row;
	prow_t              ld_row;
	logic [ID_W-1:0]    fifo_rd;
	logic               row_we;
	prow_t              wr_row;
	logic               push;
	logic               out_load;

	ptime_t             alu_a;
	ptime_t             alu_b;
	logic               alu_sub;
	ptime_t             alu_y;

	always_comb begin
		alu_a = row_q.run;
		alu_b = d_q;
		alu_sub = 1'b0;
		case (st_q)
			ST_ID1: begin
				alu_a = t_q;
				alu_b = last_q;
				alu_sub = 1'b1;
			end
			ST_ID2: begin
				alu_a = idle_q;
			end
			ST_SUB: begin
				alu_a = t_q;
				alu_b = rd_row.entry;
				alu_sub = 1'b1;
			end
			ST_ADD: begin
				case (row_q.st)
					PS_READY: alu_a = row_q.rdy;
					PS_BLOCKED: alu_a = row_q.blk;
					default: alu_a = row_q.run;
				endcase
			end
			default: ;
		endcase
	end

	assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + TIME_BITS'(alu_sub);

	// record as loaded from the table: free when never created, cleared on create
	always_comb begin
		ld_row = rd_row;
		if (!vld_q[tgt_q]) begin
			ld_row.st = PS_FREE;
		end
		if (!disp_q && cmd_q == CMD_CREATE) begin
			ld_row.run = '0;
			ld_row.rdy = '0;
			ld_row.blk = '0;
		end
	end

	assign row_we = (st_q == ST_WR);
	assign wr_row = '{st: to_q, entry: t_q, run: row_q.run, rdy: row_q.rdy, blk: row_q.blk};
	assign push = row_we && !disp_q && (to_q == PS_READY) && (cnt_q < CNT_W'(MAX_PROCS));
	assign out_load = (st_q == ST_DONE) && (!ov_q || res.ready);

	pdst_ram #(.WIDTH($bits(prow_t)), .DEPTH(MAX_PROCS)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (tgt_q),
		.wdata (wr_row),
		.raddr (tgt_q),
		.rdata (rd_row)
	);

	pdst_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_fifo (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (tgt_q),
		.raddr (head_q),
		.rdata (fifo_rd)
	);

	assign evt.ready = (st_q == ST_IDLE);
	assign res.valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			last_q <= '0;
			idle_q <= '0;
			was_idle_q <= 1'b1;
			cur_q <= '0;
			cur_vld_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			disp_q <= 1'b0;
			for (int i = 0; i < MAX_PROCS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && res.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (evt.valid) begin
						cmd_q <= evt.cmd;
						pid_q <= evt.proc_id;
						t_q <= evt.event_time;
						sts_q <= STS_OK;
						ex_vld_q <= 1'b0;
						ex_id_q <= '0;
						ex_run_q <= '0;
						ex_rdy_q <= '0;
						ex_blk_q <= '0;
						disp_q <= 1'b0;
						st_q <= ST_ID1;
					end
				end
				ST_ID1: begin
					d_q <= alu_y;
					st_q <= ST_ID2;
				end
				ST_ID2: begin
					if (was_idle_q) begin
						idle_q <= alu_y;
					end
					last_q <= t_q;
					case (cmd_q)
						CMD_CREATE, CMD_WAKE: begin
							tgt_q <= pid_q;
							st_q <= ST_RD;
						end
						CMD_EXIT, CMD_BLOCK, CMD_TIMER: begin
							tgt_q <= cur_q;
							to_q <= (cmd_q == CMD_EXIT) ? PS_EXITED :
								(cmd_q == CMD_BLOCK) ? PS_BLOCKED : PS_READY;
							if (cur_vld_q) begin
								st_q <= ST_RD;
							end else begin
								sts_q <= (cmd_q == CMD_TIMER) ? STS_OK : STS_NO_RUN;
								st_q <= ST_CHK;
							end
						end
						default: begin
							sts_q <= STS_BAD_CMD;
							st_q <= ST_CHK;
						end
					endcase
				end
				ST_RD: begin
					st_q <= ST_SUB;
				end
				ST_SUB: begin
					row_q <= ld_row;
					d_q <= alu_y;
					if (!disp_q && cmd_q == CMD_CREATE) begin
						if (vld_q[tgt_q]) begin
							sts_q <= STS_IN_USE;
							st_q <= ST_CHK;
						end else begin
							to_q <= cur_vld_q ? PS_READY : PS_RUNNING;
							st_q <= ST_WR;
						end
					end else if (!disp_q && cmd_q == CMD_WAKE) begin
						to_q <= PS_READY;
						if (!vld_q[tgt_q] || rd_row.st != PS_BLOCKED) begin
							sts_q <= STS_NOT_BLOCKED;
							st_q <= ST_CHK;
						end else begin
							st_q <= ST_ADD;
						end
					end else begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					case (row_q.st)
						PS_READY: row_q.rdy <= alu_y;
						PS_RUNNING: row_q.run <= alu_y;
						PS_BLOCKED: row_q.blk <= alu_y;
						default: ;
					endcase
					st_q <= ST_WR;
				end
				ST_WR: begin
					vld_q[tgt_q] <= 1'b1;
					if (push) begin
						tail_q <= (tail_q == ID_W'(MAX_PROCS - 1)) ? '0 : tail_q + ID_W'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (disp_q || to_q == PS_RUNNING) begin
						cur_q <= tgt_q;
						cur_vld_q <= 1'b1;
					end else if (cmd_q != CMD_CREATE && cmd_q != CMD_WAKE) begin
						cur_q <= '0;
						cur_vld_q <= 1'b0;
					end
					if (!disp_q && cmd_q == CMD_EXIT) begin
						ex_vld_q <= 1'b1;
						ex_id_q <= tgt_q;
						ex_run_q <= row_q.run;
						ex_rdy_q <= row_q.rdy;
						ex_blk_q <= row_q.blk;
					end
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					st_q <= (!cur_vld_q && cnt_q != '0) ? ST_POP : ST_DONE;
				end
				ST_POP: begin
					st_q <= ST_POPW;
				end
				ST_POPW: begin
					tgt_q <= fifo_rd;
					to_q <= PS_RUNNING;
					disp_q <= 1'b1;
					head_q <= (head_q == ID_W'(MAX_PROCS - 1)) ? '0 : head_q + ID_W'(1);
					cnt_q <= cnt_q - CNT_W'(1);
					st_q <= ST_RD;
				end
				ST_DONE: begin
					if (out_load) begin
						was_idle_q <= !cur_vld_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.run_valid <= cur_vld_q;
			res.run_id <= cur_vld_q ? 6'(cur_q) : '0;
			res.exit_valid <= ex_vld_q;
			res.exit_id <= 6'(ex_id_q);
			res.exit_run_time <= 32'(ex_run_q);
			res.exit_ready_time <= 32'(ex_rdy_q);
			res.exit_blocked_time <= 32'(ex_blk_q);
			res.idle_total <= 32'(idle_q);
			res.status <= sts_q;
		end
	end
endmodule
`default_nettype wire

### sv/pdst_chk.sv
`default_nettype none
module pdst_chk
	import pdst_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        run_valid,
	input wire [5:0]  run_id,
	input wire        exit_valid,
	input wire [5:0]  exit_id,
	input wire [2:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STS_OK || status == STS_BAD_CMD || status == STS_NO_RUN ||
			status == STS_NOT_BLOCKED || status == STS_IN_USE))
		else $error("status code out of range");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_valid |-> run_id == 6'd0)
		else $error("run id set with nothing running");

	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exit_valid |-> status == STS_OK && !(run_valid && run_id == exit_id))
		else $error("exit reported with bad status or still running");
endmodule

bind process_dispatcher_with_state_times pdst_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.run_valid  (res.run_valid),
	.run_id     (res.run_id),
	.exit_valid (res.exit_valid),
	.exit_id    (res.exit_id),
	.status     (res.status)
);
`default_nettype wire
